// File: rtl/assert_macros.svh
// Assertion helpers, sampled on i_clk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define MFD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mfd_pkg.sv
`timescale 1ns / 1ps

package mfd_pkg;

    localparam int ID_W    = 11;
    localparam int WORD_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int SLOT_W  = 3;
    localparam int NUM_GIMBAL = 2;
    localparam int GIM_IDX_W  = $clog2(NUM_GIMBAL);

    localparam logic [ID_W-1:0] ID_CHASSIS_FIRST = 11'h201;
    localparam logic [ID_W-1:0] ID_CHASSIS_LAST  = 11'h204;
    localparam logic [ID_W-1:0] ID_GIMBAL_FIRST  = 11'h205;
    localparam logic [ID_W-1:0] ID_GIMBAL_LAST   = 11'h206;

    localparam logic [SLOT_W-1:0] SLOT_GIMBAL_BASE = 3'd4;

    localparam logic [WORD_W-1:0] WRAP_THRESHOLD_RST   = 16'd4096;
    localparam logic [BYTE_W-1:0] DECIMATION_LIMIT_RST = 8'd20;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THRESHOLD   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION_LIMIT = 1'd1;

    typedef struct packed {
        logic [WORD_W-1:0] turns;
        logic [WORD_W-1:0] angle;
    } t_gim_state;

    typedef struct packed {
        logic       check;
        t_gim_state next;
    } t_turn_res;

endpackage

// File: rtl/mfd_in_if.sv
`timescale 1ns / 1ps

interface mfd_in_if;
    import mfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   frame_id;
    logic [WORD_W-1:0] word_zero;
    logic [WORD_W-1:0] word_one;
    logic [WORD_W-1:0] word_two;
    logic [BYTE_W-1:0] byte_six;

    modport source (output valid, frame_id, word_zero, word_one, word_two, byte_six,
                    input ready);
    modport sink (input valid, frame_id, word_zero, word_one, word_two, byte_six,
                  output ready);
endinterface

// File: rtl/mfd_out_if.sv
`timescale 1ns / 1ps

interface mfd_out_if;
    import mfd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [SLOT_W-1:0]        motor_slot;
    logic [WORD_W-1:0]        angle_raw;
    logic signed [WORD_W-1:0] speed_rpm;
    logic signed [WORD_W-1:0] motor_current;
    logic [BYTE_W-1:0]        temperature;
    logic signed [WORD_W-1:0] turn_count;

    modport source (output valid, motor_slot, angle_raw, speed_rpm, motor_current,
                    temperature, turn_count, input ready);
    modport sink (input valid, motor_slot, angle_raw, speed_rpm, motor_current,
                  temperature, turn_count, output ready);
endinterface

// File: rtl/motor_feedback_frame_decoder_core.sv
`timescale 1ns / 1ps

// Motor feedback frame decoder. Takes one feedback frame per cycle and gives
// one result per chassis or gimbal frame; other identifiers are dropped. With
// the result side ready, a result passes through the first stage and then the
// output register; a stalled result lets one more frame into the first stage,
// then the input stalls until the result side takes the waiting result. Gimbal
// turn counts and reference angles live in a two-entry state RAM read at input
// transfer and written back as a frame that passes the decimation check leaves
// the first stage; a write-first bypass in the RAM lets consecutive frames of
// the same gimbal motor run back to back. No clearing pass after reset.
`include "assert_macros.svh"

module motor_feedback_frame_decoder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    mfd_in_if.sink                            i_in,
    mfd_out_if.source                         o_res
);
    import mfd_pkg::*;

    logic [WORD_W-1:0] r_wrap_thr;
    logic [BYTE_W-1:0] r_limit;
    logic [BYTE_W-1:0] r_skip;
    logic [BYTE_W-1:0] n_skip;

    logic                 in_acc;
    logic                 in_chassis;
    logic                 in_gimbal;
    logic [GIM_IDX_W-1:0] in_gidx;
    logic                 s1_adv;

    logic                 r_s1_valid;
    logic                 r_s1_gimbal;
    logic [GIM_IDX_W-1:0] r_s1_gidx;
    logic [SLOT_W-1:0]    r_s1_slot;
    logic [WORD_W-1:0]    r_s1_angle;
    logic [WORD_W-1:0]    r_s1_speed;
    logic [WORD_W-1:0]    r_s1_current;
    logic [BYTE_W-1:0]    r_s1_temp;

    logic                     r_out_valid;
    logic [SLOT_W-1:0]        r_out_slot;
    logic [WORD_W-1:0]        r_out_angle;
    logic signed [WORD_W-1:0] r_out_speed;
    logic signed [WORD_W-1:0] r_out_current;
    logic [BYTE_W-1:0]        r_out_temp;
    logic signed [WORD_W-1:0] r_out_turns;

    t_gim_state rd_state;
    t_turn_res  turn_res;
    logic [$bits(t_gim_state)-1:0] rd_raw;
    logic       st_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_thr <= WRAP_THRESHOLD_RST;
            r_limit    <= DECIMATION_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WRAP_THRESHOLD:   r_wrap_thr <= i_cfg_data;
                CFG_DECIMATION_LIMIT: r_limit    <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_chassis = (i_in.frame_id >= ID_CHASSIS_FIRST) &&
                        (i_in.frame_id <= ID_CHASSIS_LAST);
    assign in_gimbal  = (i_in.frame_id == ID_GIMBAL_FIRST) ||
                        (i_in.frame_id == ID_GIMBAL_LAST);
    assign in_gidx    = GIM_IDX_W'(i_in.frame_id - ID_GIMBAL_FIRST);

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= in_acc && (in_chassis || in_gimbal);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_gimbal  <= in_gimbal;
            r_s1_gidx    <= in_gidx;
            r_s1_slot    <= in_gimbal ? SLOT_GIMBAL_BASE + SLOT_W'(in_gidx)
                                      : SLOT_W'(i_in.frame_id - ID_CHASSIS_FIRST);
            r_s1_angle   <= i_in.word_zero;
            r_s1_speed   <= i_in.word_one;
            r_s1_current <= i_in.word_two;
            r_s1_temp    <= i_in.byte_six;
        end
    end

    mfd_state_ram #(
        .DEPTH (NUM_GIMBAL),
        .WIDTH ($bits(t_gim_state)),
        .AW    (GIM_IDX_W)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (in_acc && in_gimbal),
        .i_raddr (in_gidx),
        .i_we    (st_we),
        .i_waddr (r_s1_gidx),
        .i_wdata (turn_res.next),
        .o_rdata (rd_raw)
    );

    assign rd_state = t_gim_state'(rd_raw);

    mfd_turn_calc u_turn_calc (
        .i_state    (rd_state),
        .i_angle    (r_s1_angle),
        .i_wrap_thr (r_wrap_thr),
        .i_skip     (r_skip),
        .i_limit    (r_limit),
        .o_res      (turn_res)
    );

    assign st_we  = s1_adv && r_s1_gimbal && turn_res.check;
    assign n_skip = turn_res.check ? '0 : r_skip + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= '0;
        end else if (s1_adv && r_s1_gimbal) begin
            r_skip <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_slot    <= r_s1_slot;
            r_out_angle   <= r_s1_angle;
            r_out_speed   <= r_s1_gimbal ? '0 : r_s1_speed;
            r_out_current <= r_s1_gimbal ? '0 : r_s1_current;
            r_out_temp    <= r_s1_gimbal ? '0 : r_s1_temp;
            r_out_turns   <= r_s1_gimbal ? turn_res.next.turns : '0;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.motor_slot    = r_out_slot;
    assign o_res.angle_raw     = r_out_angle;
    assign o_res.speed_rpm     = r_out_speed;
    assign o_res.motor_current = r_out_current;
    assign o_res.temperature   = r_out_temp;
    assign o_res.turn_count    = r_out_turns;

    `MFD_ASSERT_NEXT(a_s1_to_out, s1_adv, r_out_valid, "stage 1 transfer lost")
    `MFD_ASSERT_IMPL(a_no_acc_stall, r_s1_valid && !s1_adv, !in_acc, "transfer into stalled stage")
    `MFD_ASSERT_NEXT(a_skip_clear, st_we, r_skip == '0, "skip counter not cleared on check")

endmodule

// File: rtl/mfd_state_ram.sv
`timescale 1ns / 1ps

module mfd_state_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // write-first: a read of the entry being written returns the new data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else if (r_vld[i_raddr]) begin
                r_rdata <= r_mem[i_raddr];
            end else begin
                r_rdata <= '0;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mfd_turn_calc.sv
`timescale 1ns / 1ps

module mfd_turn_calc (
    input  mfd_pkg::t_gim_state         i_state,
    input  logic [mfd_pkg::WORD_W-1:0]  i_angle,
    input  logic [mfd_pkg::WORD_W-1:0]  i_wrap_thr,
    input  logic [mfd_pkg::BYTE_W-1:0]  i_skip,
    input  logic [mfd_pkg::BYTE_W-1:0]  i_limit,
    output mfd_pkg::t_turn_res          o_res
);
    import mfd_pkg::*;

    logic [WORD_W:0] sum_angle;
    logic [WORD_W:0] sum_last;
    logic            step_up;
    logic            step_down;
    logic [WORD_W-1:0] turns_new;

    assign sum_angle = {1'b0, i_angle} + {1'b0, i_wrap_thr};
    assign sum_last  = {1'b0, i_state.angle} + {1'b0, i_wrap_thr};
    assign step_up   = sum_angle < {1'b0, i_state.angle};
    assign step_down = {1'b0, i_angle} > sum_last;

    always_comb begin
        priority if (step_up) begin
            turns_new = i_state.turns + 16'd1;
        end else if (step_down) begin
            turns_new = i_state.turns - 16'd1;
        end else begin
            turns_new = i_state.turns;
        end
    end

    always_comb begin
        o_res.check = i_skip > i_limit;
        if (o_res.check) begin
            o_res.next.turns = turns_new;
            o_res.next.angle = i_angle;
        end else begin
            o_res.next = i_state;
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import mfd_pkg::*;

    localparam int RUN_LIMIT     = 300000;
    localparam int SETTLE_CYCLES = 6;

    typedef struct {
        logic [ID_W-1:0]   frame_id;
        logic [WORD_W-1:0] word_zero;
        logic [WORD_W-1:0] word_one;
        logic [WORD_W-1:0] word_two;
        logic [BYTE_W-1:0] byte_six;
    } t_frame;

    typedef struct {
        logic [SLOT_W-1:0]        slot;
        logic [WORD_W-1:0]        angle;
        logic signed [WORD_W-1:0] speed;
        logic signed [WORD_W-1:0] current;
        logic [BYTE_W-1:0]        temp;
        logic signed [WORD_W-1:0] turns;
    } t_feedback;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mfd_in_if  in_if ();
    mfd_out_if res_if ();

    motor_feedback_frame_decoder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_res      (res_if)
    );

    // Decoder state as seen by the scoreboard
    logic [WORD_W-1:0] model_wrap_thr;
    logic [BYTE_W-1:0] model_dec_limit;
    logic [WORD_W-1:0] model_ref_angle [NUM_GIMBAL];
    logic [WORD_W-1:0] model_turns [NUM_GIMBAL];
    logic [BYTE_W-1:0] model_skip_cnt;
    t_feedback         expected_q [$];

    logic [WORD_W-1:0] shaft_angle [NUM_GIMBAL];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int err_count     = 0;
    int cycle_count   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic void predict_feedback(t_frame f);
        t_feedback r;
        int m;
        r = '{default: '0};
        if (f.frame_id >= ID_CHASSIS_FIRST && f.frame_id <= ID_CHASSIS_LAST) begin
            r.slot    = SLOT_W'(f.frame_id - ID_CHASSIS_FIRST);
            r.angle   = f.word_zero;
            r.speed   = f.word_one;
            r.current = f.word_two;
            r.temp    = f.byte_six;
            expected_q.push_back(r);
        end else if (f.frame_id >= ID_GIMBAL_FIRST && f.frame_id <= ID_GIMBAL_LAST) begin
            m = int'(f.frame_id - ID_GIMBAL_FIRST);
            if (model_skip_cnt > model_dec_limit) begin
                // full-precision compare, no 16-bit wrap on the sums
                if (int'(f.word_zero) + int'(model_wrap_thr) < int'(model_ref_angle[m]))
                    model_turns[m] = model_turns[m] + 1'b1;
                else if (int'(f.word_zero) > int'(model_ref_angle[m]) + int'(model_wrap_thr))
                    model_turns[m] = model_turns[m] - 1'b1;
                model_ref_angle[m] = f.word_zero;
                model_skip_cnt     = '0;
            end else begin
                model_skip_cnt = model_skip_cnt + 1'b1;
            end
            r.slot  = SLOT_GIMBAL_BASE + SLOT_W'(m);
            r.angle = f.word_zero;
            r.turns = model_turns[m];
            expected_q.push_back(r);
        end
    endfunction

    function automatic void check_field(string name, int expv, int actv);
        if (expv != actv) begin
            $error("%s: expected %0d, actual %0d", name, expv, actv);
            err_count++;
        end
    endfunction

    function automatic void check_feedback();
        t_feedback want;
        if (expected_q.size() == 0) begin
            $error("result with no frame pending: slot %0d", res_if.motor_slot);
            err_count++;
            return;
        end
        want = expected_q.pop_front();
        if ($isunknown({res_if.motor_slot, res_if.angle_raw, res_if.speed_rpm,
                        res_if.motor_current, res_if.temperature, res_if.turn_count})) begin
            $error("result payload has unknown bits");
            err_count++;
        end
        check_field("motor_slot", want.slot, res_if.motor_slot);
        check_field("angle_raw", want.angle, res_if.angle_raw);
        check_field("speed_rpm", want.speed, res_if.speed_rpm);
        check_field("motor_current", want.current, res_if.motor_current);
        check_field("temperature", want.temp, res_if.temperature);
        check_field("turn_count", want.turns, res_if.turn_count);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready)
                check_feedback();
            if (in_if.valid && in_if.ready)
                predict_feedback('{in_if.frame_id, in_if.word_zero, in_if.word_one,
                                   in_if.word_two, in_if.byte_six});
        end
    end

    // result side: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_frame(t_frame f);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.frame_id  <= f.frame_id;
        in_if.word_zero <= f.word_zero;
        in_if.word_one  <= f.word_one;
        in_if.word_two  <= f.word_two;
        in_if.byte_six  <= f.byte_six;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_WRAP_THRESHOLD)
            model_wrap_thr = data;
        else
            model_dec_limit = data[BYTE_W-1:0];
    endtask

    // upper data byte is junk for the 8-bit limit register
    task automatic configure(logic [WORD_W-1:0] thr, logic [BYTE_W-1:0] dec);
        write_reg(CFG_WRAP_THRESHOLD, thr);
        write_reg(CFG_DECIMATION_LIMIT, {BYTE_W'($urandom), dec});
    endtask

    function automatic t_frame rand_frame(int gimbal_pct);
        t_frame f;
        int pick;
        int m;
        f.word_zero = WORD_W'($urandom);
        f.word_one  = WORD_W'($urandom);
        f.word_two  = WORD_W'($urandom);
        f.byte_six  = BYTE_W'($urandom);
        pick = $urandom_range(99);
        if (pick < gimbal_pct) begin
            m = $urandom_range(NUM_GIMBAL - 1);
            if ($urandom_range(9) == 0)
                shaft_angle[m] = WORD_W'($urandom);
            else
                shaft_angle[m] = shaft_angle[m] + WORD_W'($urandom_range(12000) - 6000);
            f.frame_id  = ID_GIMBAL_FIRST + ID_W'(m);
            f.word_zero = shaft_angle[m];
        end else if (pick < gimbal_pct + (100 - gimbal_pct) * 3 / 4) begin
            f.frame_id = ID_CHASSIS_FIRST + ID_W'($urandom_range(3));
        end else begin
            f.frame_id = ID_W'($urandom_range(2047));
        end
        return f;
    endfunction

    task automatic run_random(int count, int gimbal_pct);
        for (int i = 0; i < count; i++)
            send_frame(rand_frame(gimbal_pct));
    endtask

    task automatic test_chassis_and_unknown();
        logic [WORD_W-1:0] pat [4];
        logic [ID_W-1:0]   stray [4];
        t_frame f;
        pat   = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
        stray = '{11'h000, 11'h200, 11'h207, 11'h7FF};
        send_idle_pct = 25;
        recv_idle_pct = 58;
        for (int i = 0; i < 4; i++) begin
            f = '{ID_CHASSIS_FIRST + ID_W'(i), pat[i], pat[i], pat[i], pat[i][15:8]};
            send_frame(f);
        end
        for (int i = 0; i < 4; i++) begin
            f = rand_frame(0);
            f.frame_id = stray[i];
            send_frame(f);
        end
        drain_results();
    endtask

    // check on every second gimbal frame; crosses zero both ways on both motors
    task automatic test_turn_steps();
        logic [ID_W-1:0]   ids [10];
        logic [WORD_W-1:0] angles [10];
        t_frame f;
        ids    = '{11'h205, 11'h205, 11'h206, 11'h205, 11'h206,
                   11'h206, 11'h206, 11'h206, 11'h205, 11'h205};
        angles = '{16'hFFFF, 16'hFFFF, 16'h1000, 16'h0000, 16'hF000,
                   16'hF000, 16'h0800, 16'h0800, 16'h1000, 16'h1000};
        configure(16'd4096, 8'd0);
        for (int i = 0; i < 10; i++) begin
            f = rand_frame(0);
            f.frame_id  = ids[i];
            f.word_zero = angles[i];
            send_frame(f);
        end
        drain_results();
    endtask

    task automatic test_default_rates();
        configure(WRAP_THRESHOLD_RST, DECIMATION_LIMIT_RST);
        send_idle_pct = 25;
        recv_idle_pct = 58;
        run_random(250, 60);
        drain_results();
    endtask

    task automatic test_zero_threshold();
        configure(16'd0, 8'd0);
        send_idle_pct = 58;
        recv_idle_pct = 25;
        run_random(250, 60);
        drain_results();
    endtask

    task automatic test_full_threshold();
        configure(16'hFFFF, BYTE_W'($urandom_range(1, 5)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(150, 60);
        drain_results();
    endtask

    task automatic test_counter_ceiling();
        configure(WORD_W'($urandom), 8'd255);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(300, 95);
        drain_results();
    endtask

    task automatic test_backpressure();
        configure(WORD_W'($urandom_range(8192)), BYTE_W'($urandom_range(30)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left <= 400;
        run_random(60, 60);
        drain_results();
        run_random(100, 60);
        drain_results();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        in_if.valid     = 1'b0;
        in_if.frame_id  = '0;
        in_if.word_zero = '0;
        in_if.word_one  = '0;
        in_if.word_two  = '0;
        in_if.byte_six  = '0;
        res_if.ready    = 1'b0;
        model_wrap_thr  = WRAP_THRESHOLD_RST;
        model_dec_limit = DECIMATION_LIMIT_RST;
        model_skip_cnt  = '0;
        for (int i = 0; i < NUM_GIMBAL; i++) begin
            model_ref_angle[i] = '0;
            model_turns[i]     = '0;
            shaft_angle[i]     = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_chassis_and_unknown();
        test_turn_steps();
        test_default_rates();
        test_zero_threshold();
        test_full_threshold();
        test_counter_ceiling();
        test_backpressure();

        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
